// ===== rtl/core/jkv_pkg.sv =====
// Shared types, codes and character constants of the JSON key/value extractor.
package jkv_pkg;

  // Default sizes, handed to the top level as parameter defaults
  localparam int KEY_MAX_DEF   = 16;
  localparam int DOC_MAX_DEF   = 1024;
  localparam int VALUE_MAX_DEF = 255;

  // Key storage is two 64-bit registers
  localparam int KEY_BYTES = 16;

  // Entries in the queue between classifier and engine
  localparam int QUEUE_DEPTH = 2;

  // Configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 64;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_KEY_LENGTH  = 3'd0,
    CFG_KEY_LOW     = 3'd1,
    CFG_KEY_HIGH    = 3'd2,
    CFG_VALUE_LIMIT = 3'd3
  } cfg_reg_e;

  // Completion status
  typedef enum logic [1:0] {
    ST_FOUND   = 2'd0,
    ST_NO_KEY  = 2'd1,
    ST_BAD_DOC = 2'd2
  } status_e;

  // Parser phase
  typedef enum logic [2:0] {
    PH_FIRST  = 3'd0,
    PH_SEARCH = 3'd1,
    PH_SKIP   = 3'd2,
    PH_STR    = 3'd3,
    PH_ESC    = 3'd4,
    PH_BARE   = 3'd5,
    PH_DRAIN  = 3'd6
  } phase_e;

  // Characters of interest
  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam logic [7:0] CH_LBRACK = 8'h5B;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_N      = 8'h6E;
  localparam logic [7:0] CH_T      = 8'h74;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_RBRACE = 8'h7D;
  localparam logic [7:0] CH_RBRACK = 8'h5D;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_COLON  = 8'h3A;

  // Input item
  typedef struct packed {
    logic [7:0] doc_byte;
    logic       doc_last;
  } in_t;

  // Result item
  typedef struct packed {
    logic       has_char;
    logic [7:0] value_char;
    logic       done_res;
    logic [1:0] status;
  } out_t;

  // Classified byte, as queued for the engine
  typedef struct packed {
    logic [7:0] data;
    logic [7:0] esc_data;
    logic       last;
    logic       zero;
    logic       open;
    logic       quote;
    logic       bslash;
    logic       blank;
    logic       term;
  } cls_t;

  // Configuration seen by the engine
  typedef struct packed {
    logic [4:0]                 key_length;
    logic [KEY_BYTES-1:0][7:0]  key_bytes;
    logic [7:0]                 value_limit;
  } cfg_t;

endpackage

// ===== rtl/core/jkv_front.sv =====
// Front end: takes document bytes and classifies them for the engine.
module jkv_front (
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  jkv_pkg::in_t  in_data_i,
  input  logic          q_full_i,
  output logic          push_o,
  output jkv_pkg::cls_t cls_o
);

  logic [7:0] b;

  assign b          = in_data_i.doc_byte;
  assign in_stall_o = q_full_i;
  assign push_o     = in_valid_i && !q_full_i;

  // Byte classes and the resolved escape character
  always_comb begin
    cls_o.data   = b;
    cls_o.last   = in_data_i.doc_last;
    cls_o.zero   = (b == 8'h00);
    cls_o.open   = (b == jkv_pkg::CH_LBRACE) || (b == jkv_pkg::CH_LBRACK);
    cls_o.quote  = (b == jkv_pkg::CH_QUOTE);
    cls_o.bslash = (b == jkv_pkg::CH_BSLASH);
    cls_o.blank  = (b == jkv_pkg::CH_SPACE) || (b == jkv_pkg::CH_TAB);
    cls_o.term   = (b == jkv_pkg::CH_COMMA) || (b == jkv_pkg::CH_RBRACE) ||
                   (b == jkv_pkg::CH_RBRACK);
    if (b == jkv_pkg::CH_N) begin
      cls_o.esc_data = jkv_pkg::CH_LF;
    end else if (b == jkv_pkg::CH_T) begin
      cls_o.esc_data = jkv_pkg::CH_TAB;
    end else begin
      cls_o.esc_data = b;
    end
  end

endmodule

// ===== rtl/core/jkv_queue.sv =====
// Short queue of classified bytes between front end and engine.
module jkv_queue #(
  parameter int DEPTH = jkv_pkg::QUEUE_DEPTH
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  jkv_pkg::cls_t data_i,
  input  logic          pop_i,
  output jkv_pkg::cls_t data_o,
  output logic          empty_o,
  output logic          full_o
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  jkv_pkg::cls_t      mem_q [DEPTH];
  logic [PTR_W-1:0]   wr_ptr_q, rd_ptr_q;
  logic [CNT_W-1:0]   cnt_q;

  assign empty_o = (cnt_q == '0);
  assign full_o  = (cnt_q == CNT_W'(DEPTH));
  assign data_o  = mem_q[rd_ptr_q];

  // Storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  // Pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule

// ===== rtl/core/jkv_back.sv =====
// Engine: key search window, value parser and output register.
module jkv_back #(
  parameter int KEY_MAX   = jkv_pkg::KEY_MAX_DEF,
  parameter int DOC_MAX   = jkv_pkg::DOC_MAX_DEF,
  parameter int VALUE_MAX = jkv_pkg::VALUE_MAX_DEF
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  jkv_pkg::cfg_t cfg_i,
  input  logic          q_empty_i,
  input  jkv_pkg::cls_t q_data_i,
  output logic          q_pop_o,
  input  logic          out_stall_i,
  output logic          out_valid_o,
  output jkv_pkg::out_t out_data_o
);

  localparam int WIN     = KEY_MAX + 3;
  localparam int KEY_USE = (KEY_MAX < jkv_pkg::KEY_BYTES) ? KEY_MAX : jkv_pkg::KEY_BYTES;
  localparam int POS_W   = $clog2(DOC_MAX);
  localparam logic [POS_W-1:0] POS_END = POS_W'(DOC_MAX - 1);
  localparam logic [7:0] LIM_CAP = (VALUE_MAX < 255) ? 8'(VALUE_MAX) : 8'hFF;

  jkv_pkg::phase_e     phase_q, phase_d;
  logic [POS_W-1:0]    pos_q, pos_d;
  logic [7:0]          cnt_q, cnt_d, cnt_inc;
  logic [WIN-1:0][7:0] win_q, win_d, win_n, want;
  logic [WIN-1:0]      care, hit;
  logic                out_valid_q, out_valid_d;
  jkv_pkg::out_t       out_q, res;
  logic [4:0]          kl_cap, kl;
  logic [7:0]          lim;
  logic                match, emit, fin, put_char, real_end, cut;
  logic [7:0]          ch;
  jkv_pkg::cls_t       c;

  assign c           = q_data_i;
  assign q_pop_o     = !q_empty_i && (!out_valid_q || !out_stall_i);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // Key length in use: clamped, then cut at the first zero key byte
  always_comb begin
    kl_cap = (cfg_i.key_length > 5'(KEY_USE)) ? 5'(KEY_USE) : cfg_i.key_length;
    kl     = kl_cap;
    for (int i = KEY_USE - 1; i >= 0; i--) begin
      if (5'(i) < kl_cap && cfg_i.key_bytes[i] == 8'h00) begin
        kl = 5'(i);
      end
    end
  end

  assign lim = (cfg_i.value_limit > LIM_CAP) ? LIM_CAP : cfg_i.value_limit;

  // Expected window, newest byte at 0: colon, quote, key reversed, quote
  always_comb begin
    for (int j = 0; j < WIN; j++) begin
      care[j] = (j <= int'(kl) + 2);
      if (j == 0) begin
        want[j] = jkv_pkg::CH_COLON;
      end else if (j == 1 || j == int'(kl) + 2) begin
        want[j] = jkv_pkg::CH_QUOTE;
      end else if (j <= int'(kl) + 1) begin
        want[j] = cfg_i.key_bytes[4'(int'(kl) + 1 - j)];
      end else begin
        want[j] = 8'h00;
      end
    end
  end

  // Window after shifting in the current byte, and its compare
  always_comb begin
    win_n[0] = c.data;
    for (int j = 1; j < WIN; j++) begin
      win_n[j] = win_q[j-1];
    end
    for (int j = 0; j < WIN; j++) begin
      hit[j] = !care[j] || (win_n[j] == want[j]);
    end
    match = &hit;
  end

  assign cnt_inc = cnt_q + 1'b1;

  // Phase machine: one classified byte per pop
  always_comb begin
    phase_d  = phase_q;
    pos_d    = pos_q;
    cnt_d    = cnt_q;
    win_d    = win_q;
    res      = '0;
    emit     = 1'b0;
    fin      = 1'b0;
    put_char = 1'b0;
    ch       = c.data;
    real_end = c.zero || c.last;
    cut      = c.zero || (pos_q >= POS_END);

    if (phase_q == jkv_pkg::PH_DRAIN) begin
      if (real_end) begin
        phase_d = jkv_pkg::PH_FIRST;
        pos_d   = '0;
      end
    end else if (cut) begin
      // End of document in any phase but drain
      fin = 1'b1;
      unique case (phase_q)
        jkv_pkg::PH_FIRST:  res.status = jkv_pkg::ST_BAD_DOC;
        jkv_pkg::PH_SEARCH: res.status = jkv_pkg::ST_NO_KEY;
        jkv_pkg::PH_ESC: begin
          res.has_char   = 1'b1;
          res.value_char = jkv_pkg::CH_BSLASH;
        end
        default:            res.status = jkv_pkg::ST_FOUND;
      endcase
    end else begin
      pos_d = pos_q + 1'b1;
      unique case (phase_q)
        jkv_pkg::PH_FIRST: begin
          cnt_d = '0;
          win_d = '0;
          if (!c.open) begin
            fin        = 1'b1;
            res.status = jkv_pkg::ST_BAD_DOC;
          end else begin
            win_d[0] = c.data;
            phase_d  = jkv_pkg::PH_SEARCH;
            if (c.last) begin
              fin        = 1'b1;
              res.status = jkv_pkg::ST_NO_KEY;
            end
          end
        end
        jkv_pkg::PH_SEARCH: begin
          win_d = win_n;
          if (match) begin
            phase_d = jkv_pkg::PH_SKIP;
            fin     = c.last;
          end else if (c.last) begin
            fin        = 1'b1;
            res.status = jkv_pkg::ST_NO_KEY;
          end
        end
        jkv_pkg::PH_SKIP: begin
          if (c.blank) begin
            fin = c.last;
          end else if (lim == 8'h00) begin
            fin = 1'b1;
          end else if (c.quote) begin
            phase_d = jkv_pkg::PH_STR;
            fin     = c.last;
          end else if (c.term) begin
            fin = 1'b1;
          end else begin
            phase_d  = jkv_pkg::PH_BARE;
            put_char = 1'b1;
          end
        end
        jkv_pkg::PH_STR: begin
          if (c.quote) begin
            fin = 1'b1;
          end else if (c.bslash && !c.last) begin
            phase_d = jkv_pkg::PH_ESC;
          end else begin
            // a backslash on the last byte goes out literally
            put_char = 1'b1;
          end
        end
        jkv_pkg::PH_ESC: begin
          phase_d  = jkv_pkg::PH_STR;
          put_char = 1'b1;
          ch       = c.esc_data;
        end
        default: begin
          // bare value
          if (c.term) begin
            fin = 1'b1;
          end else begin
            put_char = 1'b1;
          end
        end
      endcase
    end

    // Value character, done at the limit or the document end
    if (put_char) begin
      cnt_d          = cnt_inc;
      res.has_char   = 1'b1;
      res.value_char = ch;
      if (cnt_inc >= lim || c.last) begin
        fin = 1'b1;
      end
    end

    if (fin) begin
      res.done_res = 1'b1;
      if (real_end) begin
        phase_d = jkv_pkg::PH_FIRST;
        pos_d   = '0;
      end else begin
        phase_d = jkv_pkg::PH_DRAIN;
      end
    end
    emit = put_char || fin;

    out_valid_d = q_pop_o ? emit : (out_valid_q && out_stall_i);
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= jkv_pkg::PH_FIRST;
      pos_q       <= '0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      if (q_pop_o) begin
        phase_q <= phase_d;
        pos_q   <= pos_d;
        cnt_q   <= cnt_d;
      end
    end
  end

  // Window and result payload
  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      win_q <= win_d;
      if (emit) begin
        out_q <= res;
      end
    end
  end

  // A result that is not the last one always carries a character
  a_mid_has_char: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !out_q.done_res |-> out_q.has_char && out_q.status == jkv_pkg::ST_FOUND)
    else $error("non-final result without a character");

  // No character means a zero character field
  a_char_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !out_q.has_char |-> out_q.value_char == 8'h00)
    else $error("value_char set without has_char");

  // Position never runs past the document cut
  a_pos_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pos_q <= POS_END)
    else $error("byte position beyond document limit");

  // A produced result is presented on the next cycle
  a_emit_shown: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop_o && emit |=> out_valid_q)
    else $error("result lost in output register");

endmodule

// ===== rtl/core/json_key_value_extractor_top.sv =====
// Top level of the JSON key/value extractor: configuration registers and datapath.
//
//  channel  direction  handshake                  payload
//  in       input      in_valid_i / in_stall_o    in_data_i  (doc_byte, doc_last)
//  out      output     out_valid_o / out_stall_i  out_data_o (has_char, value_char,
//                                                            done_res, status)
//  cfg      input      cfg_we_i                   cfg_idx_i, cfg_data_i
//
// One byte per cycle sustained while the output is not stalled; after its byte is taken, a
// result passes the queue write, then the engine's window compare and phase update, and is
// then held in the output register.
// Reset clears the queue, the output valid flag and the parser, and loads the register
// defaults; no clearing pass is needed.
// A stalled output holds the engine; the two-entry queue then fills and in_stall_o rises.
module json_key_value_extractor_top #(
  parameter int KEY_MAX   = jkv_pkg::KEY_MAX_DEF,
  parameter int DOC_MAX   = jkv_pkg::DOC_MAX_DEF,
  parameter int VALUE_MAX = jkv_pkg::VALUE_MAX_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  jkv_pkg::in_t                   in_data_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output jkv_pkg::out_t                  out_data_o,
  input  logic                           cfg_we_i,
  input  logic [jkv_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [jkv_pkg::CFG_DATA_W-1:0] cfg_data_i
);

  logic [4:0]          key_len_q;
  logic [63:0]         key_lo_q, key_hi_q;
  logic [7:0]          limit_q;
  jkv_pkg::cfg_t       cfg;
  jkv_pkg::cls_t       cls_in, cls_out;
  logic                push, pop, q_empty, q_full;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_len_q <= 5'd1;
      key_lo_q  <= '0;
      key_hi_q  <= '0;
      limit_q   <= 8'd63;
    end else if (cfg_we_i) begin
      unique case (jkv_pkg::cfg_reg_e'(cfg_idx_i))
        jkv_pkg::CFG_KEY_LENGTH:  key_len_q <= cfg_data_i[4:0];
        jkv_pkg::CFG_KEY_LOW:     key_lo_q  <= cfg_data_i;
        jkv_pkg::CFG_KEY_HIGH:    key_hi_q  <= cfg_data_i;
        jkv_pkg::CFG_VALUE_LIMIT: limit_q   <= cfg_data_i[7:0];
        default: ;
      endcase
    end
  end

  assign cfg.key_length  = key_len_q;
  assign cfg.key_bytes   = {key_hi_q, key_lo_q};
  assign cfg.value_limit = limit_q;

  jkv_front u_front (
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .q_full_i   (q_full),
    .push_o     (push),
    .cls_o      (cls_in)
  );

  jkv_queue #(
    .DEPTH (jkv_pkg::QUEUE_DEPTH)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (cls_in),
    .pop_i   (pop),
    .data_o  (cls_out),
    .empty_o (q_empty),
    .full_o  (q_full)
  );

  jkv_back #(
    .KEY_MAX   (KEY_MAX),
    .DOC_MAX   (DOC_MAX),
    .VALUE_MAX (VALUE_MAX)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .q_empty_i   (q_empty),
    .q_data_i    (cls_out),
    .q_pop_o     (pop),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .out_data_o  (out_data_o)
  );

endmodule

// ===== tb/tb_top.sv =====
// Testbench of the JSON key/value extractor: directed and random documents, checked per result.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import jkv_pkg::*;

  localparam int KEY_MAX   = KEY_MAX_DEF;
  localparam int DOC_MAX   = DOC_MAX_DEF;
  localparam int VALUE_MAX = VALUE_MAX_DEF;
  localparam int WIN       = KEY_MAX + 3;

  typedef logic [7:0] byte_q_t[$];

  // DUT connections, all inputs driven to known values from time zero
  logic                  clk_i       = 1'b0;
  logic                  rst_ni      = 1'b0;
  logic                  in_valid_i  = 1'b0;
  logic                  in_stall_o;
  in_t                   in_data_i   = '0;
  logic                  out_valid_o;
  logic                  out_stall_i = 1'b0;
  out_t                  out_data_o;
  logic                  cfg_we_i    = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx_i   = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i  = '0;

  json_key_value_extractor_top DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i)
  );

  // Idling percentages of the two sides
  int idle_pct  = 0;
  int stall_pct = 0;

  int mismatches = 0;
  int bytes_sent = 0;

  // Register shadows
  logic [4:0]  key_len_r;
  logic [63:0] key_lo_r;
  logic [63:0] key_hi_r;
  logic [7:0]  val_lim_r;

  // Parser state of the predictor
  logic [7:0]  recent_bytes [WIN];
  phase_e      doc_phase;
  logic [7:0]  emit_cnt;
  int unsigned doc_pos;

  out_t        extract_q [$];
  out_t        want;
  byte_q_t     doc_buf;
  byte_q_t     cur_key;

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  // Watchdog
  initial begin
    #1_000_000;
    $display("TB_ERROR");
    $finish;
  end

  // ---------------------------------------------------------------- predictor

  function automatic logic [7:0] key_at(int i);
    logic [63:0] w;
    w = (i < 8) ? key_lo_r : key_hi_r;
    return w[(i % 8) * 8 +: 8];
  endfunction

  // Key length in use: clamped, then cut at the first zero byte
  function automatic int eff_key_len();
    int kl;
    kl = key_len_r;
    if (kl > KEY_MAX) kl = KEY_MAX;
    if (kl > KEY_BYTES) kl = KEY_BYTES;
    for (int i = 0; i < kl; i++) if (key_at(i) == 8'd0) return i;
    return kl;
  endfunction

  function automatic int lim_now();
    return (val_lim_r > VALUE_MAX) ? VALUE_MAX : int'(val_lim_r);
  endfunction

  // Newest byte sits at index 0; look for quote, key, quote, colon ending there
  function automatic bit key_seen();
    int kl;
    int len;
    logic [7:0] c;
    kl  = eff_key_len();
    len = kl + 3;
    if (doc_pos < len || len > WIN) return 1'b0;
    for (int i = 0; i < len; i++) begin
      if (i == 0 || i == kl + 1) c = CH_QUOTE;
      else if (i == kl + 2) c = CH_COLON;
      else c = key_at(i - 1);
      if (recent_bytes[len - 1 - i] != c) return 1'b0;
    end
    return 1'b1;
  endfunction

  function automatic void shift_byte(logic [7:0] b);
    for (int i = WIN - 1; i > 0; i--) recent_bytes[i] = recent_bytes[i - 1];
    recent_bytes[0] = b;
  endfunction

  function automatic out_t mk_result(bit has, logic [7:0] ch, bit fin, status_e st);
    out_t r;
    r.has_char   = has;
    r.value_char = has ? ch : 8'd0;
    r.done_res   = fin;
    r.status     = fin ? st : ST_FOUND;
    return r;
  endfunction

  function automatic out_t emit_value(logic [7:0] ch, bit last);
    emit_cnt = emit_cnt + 8'd1;
    return mk_result(1'b1, ch, (int'(emit_cnt) >= lim_now()) || last, ST_FOUND);
  endfunction

  function automatic bit is_term(logic [7:0] b);
    return b == CH_COMMA || b == CH_RBRACE || b == CH_RBRACK;
  endfunction

  function automatic void model_reset();
    key_len_r = 5'd1;
    key_lo_r  = '0;
    key_hi_r  = '0;
    val_lim_r = 8'd63;
    foreach (recent_bytes[i]) recent_bytes[i] = 8'd0;
    doc_phase = PH_FIRST;
    emit_cnt  = 8'd0;
    doc_pos   = 0;
  endfunction

  // Work out the result (if any) of one accepted document byte
  function automatic void predict_extract(in_t it);
    logic [7:0] b;
    bit last;
    bit real_end;
    bit cut;
    bit got;
    phase_e ph;
    out_t r;
    b        = it.doc_byte;
    last     = it.doc_last;
    real_end = (b == 8'd0) || last;
    cut      = (b == 8'd0) || (doc_pos >= DOC_MAX - 1);
    ph       = doc_phase;
    got      = 1'b0;
    r        = '0;

    // Skipping the rest of a finished document
    if (ph == PH_DRAIN) begin
      if (real_end) begin
        doc_phase = PH_FIRST;
        doc_pos   = 0;
      end
      return;
    end

    if (cut) begin
      got = 1'b1;
      case (ph)
        PH_FIRST:  r = mk_result(1'b0, 8'd0, 1'b1, ST_BAD_DOC);
        PH_SEARCH: r = mk_result(1'b0, 8'd0, 1'b1, ST_NO_KEY);
        PH_ESC:    r = mk_result(1'b1, CH_BSLASH, 1'b1, ST_FOUND);
        default:   r = mk_result(1'b0, 8'd0, 1'b1, ST_FOUND);
      endcase
    end else begin
      doc_pos++;
      case (ph)
        PH_FIRST: begin
          foreach (recent_bytes[i]) recent_bytes[i] = 8'd0;
          emit_cnt = 8'd0;
          if (b != CH_LBRACE && b != CH_LBRACK) begin
            r   = mk_result(1'b0, 8'd0, 1'b1, ST_BAD_DOC);
            got = 1'b1;
          end else begin
            shift_byte(b);
            doc_phase = PH_SEARCH;
            if (last) begin
              r   = mk_result(1'b0, 8'd0, 1'b1, ST_NO_KEY);
              got = 1'b1;
            end
          end
        end
        PH_SEARCH: begin
          shift_byte(b);
          if (key_seen()) begin
            doc_phase = PH_SKIP;
            if (last) begin
              r   = mk_result(1'b0, 8'd0, 1'b1, ST_FOUND);
              got = 1'b1;
            end
          end else if (last) begin
            r   = mk_result(1'b0, 8'd0, 1'b1, ST_NO_KEY);
            got = 1'b1;
          end
        end
        PH_SKIP: begin
          if (b == CH_SPACE || b == CH_TAB) begin
            if (last) begin
              r   = mk_result(1'b0, 8'd0, 1'b1, ST_FOUND);
              got = 1'b1;
            end
          end else if (lim_now() == 0) begin
            r   = mk_result(1'b0, 8'd0, 1'b1, ST_FOUND);
            got = 1'b1;
          end else if (b == CH_QUOTE) begin
            doc_phase = PH_STR;
            if (last) begin
              r   = mk_result(1'b0, 8'd0, 1'b1, ST_FOUND);
              got = 1'b1;
            end
          end else if (is_term(b)) begin
            r   = mk_result(1'b0, 8'd0, 1'b1, ST_FOUND);
            got = 1'b1;
          end else begin
            doc_phase = PH_BARE;
            r   = emit_value(b, last);
            got = 1'b1;
          end
        end
        PH_STR: begin
          if (b == CH_QUOTE) begin
            r   = mk_result(1'b0, 8'd0, 1'b1, ST_FOUND);
            got = 1'b1;
          end else if (b == CH_BSLASH) begin
            if (last) begin
              r   = emit_value(CH_BSLASH, 1'b1);
              got = 1'b1;
            end else begin
              doc_phase = PH_ESC;
            end
          end else begin
            r   = emit_value(b, last);
            got = 1'b1;
          end
        end
        PH_ESC: begin
          doc_phase = PH_STR;
          r   = emit_value((b == CH_N) ? CH_LF : ((b == CH_T) ? CH_TAB : b), last);
          got = 1'b1;
        end
        default: begin
          if (is_term(b)) r = mk_result(1'b0, 8'd0, 1'b1, ST_FOUND);
          else r = emit_value(b, last);
          got = 1'b1;
        end
      endcase
    end

    if (got && r.done_res) begin
      if (real_end) begin
        doc_phase = PH_FIRST;
        doc_pos   = 0;
      end else begin
        doc_phase = PH_DRAIN;
      end
    end
    if (got) extract_q.push_back(r);
  endfunction

  // ---------------------------------------------------------------- result side

  always @(posedge clk_i) begin
    out_stall_i <= ($urandom_range(99) < stall_pct);
  end

  function automatic void flag_mismatch(string what, out_t exp_r, out_t got_r);
    mismatches++;
    if (mismatches <= 10)
      $display("%0t: %s: expected has=%0b char=%02h done=%0b st=%0d,",
               $realtime, what, exp_r.has_char, exp_r.value_char, exp_r.done_res,
               exp_r.status, " got has=%0b char=%02h done=%0b st=%0d",
               got_r.has_char, got_r.value_char, got_r.done_res, got_r.status);
  endfunction

  // Compare each accepted result with the oldest expectation
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (extract_q.size() == 0) begin
        flag_mismatch("result with none pending", '0, out_data_o);
      end else begin
        want = extract_q.pop_front();
        if (out_data_o.has_char !== want.has_char ||
            out_data_o.value_char !== want.value_char ||
            out_data_o.done_res !== want.done_res || out_data_o.status !== want.status)
          flag_mismatch("result mismatch", want, out_data_o);
      end
    end
  end

  // ---------------------------------------------------------------- drive side

  function automatic int draw_gap();
    int n;
    n = 0;
    while (n < 40 && $urandom_range(99) < idle_pct) n++;
    return n;
  endfunction

  // Send one document byte and predict its result once it is taken
  task automatic send_item(input in_t it);
    int gap;
    gap = draw_gap();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= it;
    do @(posedge clk_i); while (in_stall_o);
    predict_extract(it);
    bytes_sent++;
  endtask

  // Send doc_buf, ended by the last flag or by a trailing zero byte
  task automatic send_doc(input bit zero_end);
    in_t it;
    foreach (doc_buf[i]) begin
      it.doc_byte = doc_buf[i];
      it.doc_last = !zero_end && (i == doc_buf.size() - 1);
      send_item(it);
    end
    if (zero_end) begin
      it.doc_byte = 8'd0;
      it.doc_last = 1'($urandom_range(1));
      send_item(it);
    end
  endtask

  function automatic byte_q_t text_bytes(string s);
    byte_q_t q;
    for (int i = 0; i < s.len(); i++) q.push_back(s[i]);
    return q;
  endfunction

  function automatic void put_text(string s);
    for (int i = 0; i < s.len(); i++) doc_buf.push_back(s[i]);
  endfunction

  task automatic run_doc(input string s, input bit zero_end);
    doc_buf = {};
    put_text(s);
    send_doc(zero_end);
  endtask

  // Let every pending result out and the pipeline run empty
  task automatic quiesce();
    in_valid_i <= 1'b0;
    while (extract_q.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic write_reg(input cfg_reg_e idx, input logic [63:0] d);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= d;
    @(posedge clk_i);
    case (idx)
      CFG_KEY_LENGTH:  key_len_r = d[4:0];
      CFG_KEY_LOW:     key_lo_r  = d;
      CFG_KEY_HIGH:    key_hi_r  = d;
      CFG_VALUE_LIMIT: val_lim_r = d[7:0];
      default: ;
    endcase
  endtask

  // Load the key and the value limit; unused upper bits carry noise
  task automatic set_key(input byte_q_t k, input logic [4:0] kl, input logic [7:0] lim);
    logic [63:0] lo;
    logic [63:0] hi;
    logic [63:0] d;
    int n;
    lo = '0;
    hi = '0;
    foreach (k[i]) begin
      if (i < 8) lo[i * 8 +: 8] = k[i];
      else if (i < 16) hi[(i - 8) * 8 +: 8] = k[i];
    end
    quiesce();
    d = {$urandom, $urandom};
    write_reg(CFG_KEY_LENGTH, {d[63:5], kl});
    write_reg(CFG_KEY_LOW, lo);
    write_reg(CFG_KEY_HIGH, hi);
    d = {$urandom, $urandom};
    write_reg(CFG_VALUE_LIMIT, {d[63:8], lim});
    cfg_we_i <= 1'b0;
    n = eff_key_len();
    cur_key = {};
    for (int i = 0; i < n; i++) cur_key.push_back(key_at(i));
  endtask

  // ---------------------------------------------------------------- tests

  // Register defaults: the key in use is empty, so "": is the pattern
  task automatic test_reset_defaults();
    run_doc("{\"\":\"ab\"}", 1'b0);
    run_doc("[\"x\":1,\"\": 5]", 1'b1);
  endtask

  task automatic test_document_start();
    run_doc("xyz", 1'b0);
    doc_buf = {};
    send_doc(1'b1);
    run_doc("[", 1'b0);
    run_doc("{\"a\":1", 1'b1);
    doc_buf = {};
    doc_buf.push_back(8'hFF);
    put_text("{}");
    send_doc(1'b0);
  endtask

  task automatic test_key_lengths();
    byte_q_t k;
    set_key(text_bytes("name"), 5'd4, 8'd63);
    run_doc("{\"id\":7,\"name\":\"Bo\"}", 1'b0);
    k = text_bytes("abcdefghijklmnop");
    set_key(k, 5'd16, 8'd63);
    run_doc("{\"abcdefghijklmnop\":true}", 1'b1);
    set_key(k, 5'd31, 8'd63);
    run_doc("[\"abcdefghijklmnop\": 42]", 1'b0);
    // a zero key byte shortens the key
    k = text_bytes("ab?cd");
    k[2] = 8'd0;
    set_key(k, 5'd5, 8'd63);
    run_doc("{\"ab\":x}", 1'b0);
    k = {};
    repeat (16) k.push_back(8'hFF);
    set_key(k, 5'd16, 8'd255);
    doc_buf = {};
    put_text("{\"");
    repeat (16) doc_buf.push_back(8'hFF);
    put_text("\":\"\\t\"}");
    send_doc(1'b1);
  endtask

  task automatic test_string_values();
    set_key(text_bytes("s"), 5'd1, 8'd63);
    run_doc("{\"s\":\"a\\n\\t\\q\\\\\\\"z\"}", 1'b0);
    // backslash as final byte, then backslash before a zero byte
    run_doc("{\"s\":\"ab\\", 1'b0);
    run_doc("{\"s\":\"a\\", 1'b1);
    run_doc("{\"s\":\"abc", 1'b0);
  endtask

  task automatic test_bare_values();
    run_doc("{\"s\": \t-12.5,\"t\":1}", 1'b0);
    run_doc("[\"s\":true]", 1'b1);
    run_doc("{\"s\":null", 1'b0);
    run_doc("{\"s\":}", 1'b0);
  endtask

  // Document ends at the colon or in the blanks
  task automatic test_empty_values();
    run_doc("{\"s\":", 1'b0);
    run_doc("{\"s\":  \t", 1'b0);
    run_doc("{\"s\": ", 1'b1);
  endtask

  task automatic test_value_limit();
    set_key(text_bytes("s"), 5'd1, 8'd0);
    run_doc("{\"s\":\"abc\"}", 1'b0);
    set_key(text_bytes("s"), 5'd1, 8'd3);
    run_doc("{\"s\":\"abcdef\"}", 1'b1);
    set_key(text_bytes("s"), 5'd1, 8'd1);
    run_doc("{\"s\":7,\"t\":8}", 1'b0);
    set_key(text_bytes("s"), 5'd1, 8'd255);
    doc_buf = {};
    put_text("{\"s\":\"");
    for (int i = 0; i < 40; i++) doc_buf.push_back(8'h61 + 8'(i % 26));
    put_text("\"}");
    send_doc(1'b0);
  endtask

  task automatic random_config();
    byte_q_t k;
    int n;
    logic [4:0] kl;
    logic [7:0] lim;
    n = $urandom_range(1, 16);
    repeat (n) k.push_back(($urandom_range(7) == 0) ? 8'($urandom_range(1, 255))
                                                   : 8'($urandom_range(97, 122)));
    case ($urandom_range(5))
      0:       kl = 5'd0;
      1:       kl = 5'($urandom_range(n, 31));
      default: kl = 5'(n);
    endcase
    case ($urandom_range(5))
      0:       lim = 8'd0;
      1:       lim = 8'($urandom_range(1, 3));
      2:       lim = 8'd255;
      3:       lim = 8'd63;
      default: lim = 8'($urandom_range(4, 20));
    endcase
    set_key(k, kl, lim);
  endtask

  // Mostly well-formed documents holding the key, some cut short, some noise
  function automatic void random_doc();
    string bare_set;
    int kind;
    int n;
    int cut_at;
    logic [7:0] c;
    bare_set = "-+.0123456789eEtrufalsn ";
    kind = $urandom_range(99);
    doc_buf = {};
    if (kind >= 85) begin
      doc_buf.push_back(($urandom_range(3) == 0) ? 8'($urandom)
                        : ($urandom_range(1) ? CH_LBRACE : CH_LBRACK));
      repeat ($urandom_range(1, 20)) doc_buf.push_back(8'($urandom));
      return;
    end
    doc_buf.push_back($urandom_range(1) ? CH_LBRACE : CH_LBRACK);
    // decoy members, some starting like the key
    repeat ($urandom_range(2)) begin
      doc_buf.push_back(CH_QUOTE);
      if ($urandom_range(3) == 0) foreach (cur_key[i]) doc_buf.push_back(cur_key[i]);
      repeat ($urandom_range(1, 4)) doc_buf.push_back(8'($urandom_range(97, 122)));
      put_text("\":0,");
    end
    doc_buf.push_back(CH_QUOTE);
    foreach (cur_key[i]) doc_buf.push_back(cur_key[i]);
    doc_buf.push_back(CH_QUOTE);
    doc_buf.push_back(CH_COLON);
    repeat ($urandom_range(3)) doc_buf.push_back($urandom_range(1) ? CH_SPACE : CH_TAB);
    n = ($urandom_range(9) == 0) ? $urandom_range(40, 80) : $urandom_range(10);
    if ($urandom_range(1)) begin
      doc_buf.push_back(CH_QUOTE);
      repeat (n) begin
        case ($urandom_range(9))
          0: begin
            doc_buf.push_back(CH_BSLASH);
            case ($urandom_range(4))
              0:       doc_buf.push_back(CH_N);
              1:       doc_buf.push_back(CH_T);
              2:       doc_buf.push_back(CH_QUOTE);
              3:       doc_buf.push_back(CH_BSLASH);
              default: doc_buf.push_back(8'($urandom_range(1, 255)));
            endcase
          end
          1: doc_buf.push_back(8'($urandom_range(128, 255)));
          default: begin
            c = 8'($urandom_range(32, 126));
            if (c == CH_QUOTE || c == CH_BSLASH) c = 8'h78;
            doc_buf.push_back(c);
          end
        endcase
      end
      doc_buf.push_back(CH_QUOTE);
      doc_buf.push_back(CH_RBRACE);
    end else begin
      repeat (n) doc_buf.push_back(bare_set[$urandom_range(bare_set.len() - 1)]);
      case ($urandom_range(2))
        0:       put_text(",\"z\":1}");
        1:       doc_buf.push_back(CH_RBRACE);
        default: doc_buf.push_back(CH_RBRACK);
      endcase
    end
    if (kind >= 70) begin
      cut_at = $urandom_range(1, doc_buf.size());
      while (doc_buf.size() > cut_at) void'(doc_buf.pop_back());
    end
  endfunction

  task automatic test_random(input int n_bytes);
    int stop_at;
    int docs;
    stop_at = bytes_sent + n_bytes;
    docs = 0;
    while (bytes_sent < stop_at) begin
      if (docs % 6 == 0) random_config();
      random_doc();
      send_doc(1'($urandom_range(1)));
      docs++;
    end
  endtask

  // ---------------------------------------------------------------- sequence

  initial begin
    model_reset();
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_defaults();
    test_document_start();
    test_key_lengths();
    test_string_values();
    test_bare_values();
    test_empty_values();
    test_value_limit();

    test_random(90);
    idle_pct = 88;
    test_random(90);
    idle_pct  = 0;
    stall_pct = 88;
    test_random(90);
    idle_pct  = 22;
    stall_pct = 22;
    test_random(90);

    quiesce();
    if (mismatches == 0 && extract_q.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
